FILE: rtl/core/bga_pkg.sv
// ----------------------------------------------------------------------------
// bga_pkg: shared types and constants for the battery gauge
// Beat layouts, window length and the fixed-point reciprocals used to divide
// by constants without a divider.
// ----------------------------------------------------------------------------
package bga_pkg;

    // Averaging window: the new sample plus WINDOW_LEN-1 stored samples.
    localparam int unsigned WINDOW_LEN = 10;
    localparam int unsigned HIST_LEN   = WINDOW_LEN - 1;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned ADC_FULL = 4095;
    localparam int unsigned SUM_W    = $clog2(ADC_FULL * WINDOW_LEN + 1);

    // Exact floor(sum / WINDOW_LEN) as (sum * AVG_RECIP) >> AVG_SHIFT.
    localparam int unsigned AVG_SHIFT   = SUM_W + $clog2(WINDOW_LEN);
    localparam int unsigned AVG_RECIP   = ((1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int unsigned AVG_RECIP_W = SUM_W + 1;
    localparam int unsigned AVG_PROD_W  = SUM_W + AVG_RECIP_W;

    // Scaling to millivolts at the ADC pin.
    localparam int unsigned REF_MV     = 3300;
    localparam int unsigned MV_PROD_W  = 24;
    // Exact floor(p / 4095) for p below 2^24 as ((p + 1) * 4097) >> 24.
    localparam int unsigned SCALE_RECIP   = ADC_FULL + 2;
    localparam int unsigned SCALE_RECIP_W = 13;
    localparam int unsigned SCALE_SHIFT   = 24;
    localparam int unsigned SCALE_PROD_W  = MV_PROD_W + SCALE_RECIP_W;

    // Clamp range and percentage.
    localparam int unsigned MV_W     = 12;
    localparam int unsigned MV_MIN   = 3300;
    localparam int unsigned MV_MAX   = 3900;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned PCT_FULL = 100;
    localparam int unsigned PCT_D_W  = $clog2(MV_MAX - MV_MIN + 1);
    // The clamped voltage is always even, so (d * 100 / 600) = (d / 2) / 3,
    // and floor(h / 3) for h up to 300 is (h * 683) >> 11.
    localparam int unsigned PCT_H_W      = PCT_D_W - 1;
    localparam int unsigned PCT_RECIP    = 683;
    localparam int unsigned PCT_RECIP_W  = 10;
    localparam int unsigned PCT_SHIFT    = 11;
    localparam int unsigned PCT_PROD_W   = PCT_H_W + PCT_RECIP_W;

    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
        logic                charger_pin_level;
    } bga_in_t;

    typedef struct packed {
        logic [MV_W-1:0]  battery_mv;
        logic [PCT_W-1:0] battery_percent;
        logic             charging;
    } bga_out_t;

    // Window sum and pin level handed from the history stage to the scaler.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             pin;
    } bga_sum_t;

endpackage

FILE: rtl/core/bga_history.sv
// ----------------------------------------------------------------------------
// bga_history: sample history and running window sum
// Keeps the previous samples in a shift line with a running sum of them, and
// registers the full window sum of each accepted beat.
// ----------------------------------------------------------------------------
module bga_history (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bga_pkg::bga_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bga_pkg::bga_sum_t out_data
);
    import bga_pkg::*;

    logic [SAMPLE_W-1:0] hist_reg [HIST_LEN];
    logic [SUM_W-1:0]    hist_sum_reg;
    logic [SUM_W-1:0]    hist_sum_next;
    logic [SUM_W-1:0]    win_sum;
    logic                valid_reg;
    bga_sum_t            data_reg;
    logic                accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign win_sum       = hist_sum_reg + SUM_W'(in_data.adc_sample);
    assign hist_sum_next = win_sum - SUM_W'(hist_reg[HIST_LEN-1]);

    // The shift line resets to the full-scale value in the newest entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i < HIST_LEN; i++) begin
                hist_reg[i] <= '0;
            end
            hist_reg[0]  <= SAMPLE_W'(ADC_FULL);
            hist_sum_reg <= SUM_W'(ADC_FULL);
        end else if (accept) begin
            for (int i = HIST_LEN - 1; i > 0; i--) begin
                hist_reg[i] <= hist_reg[i-1];
            end
            hist_reg[0]  <= in_data.adc_sample;
            hist_sum_reg <= hist_sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg.sum <= win_sum;
            data_reg.pin <= in_data.charger_pin_level;
        end
    end

endmodule

FILE: rtl/core/bga_scale.sv
// ----------------------------------------------------------------------------
// bga_scale: average, millivolt scaling, clamp and percentage
// Four registered stages, one constant multiplication in each, with the
// result register last.
// ----------------------------------------------------------------------------
module bga_scale (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bga_pkg::bga_sum_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bga_pkg::bga_out_t out_data
);
    import bga_pkg::*;

    logic v2_reg, v3_reg, v4_reg, v5_reg;
    logic en2, en3, en4, en5;

    logic [SAMPLE_W-1:0]  avg_reg;
    logic                 pin2_reg;
    logic [MV_PROD_W-1:0] prod_reg;
    logic                 pin3_reg;
    logic [SAMPLE_W-1:0]  mv_half_reg;
    logic                 pin4_reg;
    bga_out_t             res_reg;

    logic [AVG_PROD_W-1:0]   avg_prod;
    logic [MV_PROD_W-1:0]    mv_prod;
    logic [SCALE_PROD_W-1:0] scale_prod;
    logic [MV_W:0]           mv_dbl;
    logic [MV_W-1:0]         mv_clamp;
    logic [PCT_D_W-1:0]      mv_off;
    logic [PCT_PROD_W-1:0]   pct_prod;
    logic [PCT_W-1:0]        pct;

    // A stage moves on when it is empty or its successor moves on.
    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign in_ready = en2;

    assign out_valid = v5_reg;
    assign out_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en2) begin
                v2_reg <= in_valid;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Window average by reciprocal multiplication.
    assign avg_prod = AVG_PROD_W'(in_data.sum) * AVG_PROD_W'(AVG_RECIP);

    // Millivolts at the ADC pin before the divide by full scale.
    assign mv_prod = MV_PROD_W'(avg_reg) * MV_PROD_W'(REF_MV);

    // Divide by full scale, again by reciprocal.
    assign scale_prod = SCALE_PROD_W'(prod_reg + MV_PROD_W'(1)) * SCALE_PROD_W'(SCALE_RECIP);

    always_comb begin
        mv_dbl = {mv_half_reg, 1'b0};
        if (mv_dbl < (MV_W + 1)'(MV_MIN)) begin
            mv_clamp = MV_W'(MV_MIN);
        end else if (mv_dbl > (MV_W + 1)'(MV_MAX)) begin
            mv_clamp = MV_W'(MV_MAX);
        end else begin
            mv_clamp = mv_dbl[MV_W-1:0];
        end
        mv_off   = PCT_D_W'(mv_clamp - MV_W'(MV_MIN));
        pct_prod = PCT_PROD_W'(mv_off[PCT_D_W-1:1]) * PCT_PROD_W'(PCT_RECIP);
        pct      = pct_prod[PCT_SHIFT +: PCT_W];
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            avg_reg  <= avg_prod[AVG_SHIFT +: SAMPLE_W];
            pin2_reg <= in_data.pin;
        end
        if (en3) begin
            prod_reg <= mv_prod;
            pin3_reg <= pin2_reg;
        end
        if (en4) begin
            mv_half_reg <= scale_prod[SCALE_SHIFT +: SAMPLE_W];
            pin4_reg    <= pin3_reg;
        end
        if (en5) begin
            res_reg.battery_mv      <= mv_clamp;
            res_reg.battery_percent <= pct;
            res_reg.charging        <= (pct != PCT_W'(PCT_FULL)) && !pin4_reg;
        end
    end

endmodule

FILE: rtl/core/battery_gauge_averaging.sv
// ----------------------------------------------------------------------------
// battery_gauge_averaging: moving-average battery voltage and charge gauge
// Path: an accepted input beat is registered in bga_history, then in the bga_scale stages.
// Throughput: one beat per cycle unless m_ready stalls the five-stage pipeline.
// Reset: synchronous, active low; history holds full scale in the newest entry.
// ----------------------------------------------------------------------------
module battery_gauge_averaging (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bga_pkg::bga_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bga_pkg::bga_out_t m_data
);
    import bga_pkg::*;

    // The history stage keeps the previous samples in a shift line together
    // with their running sum, so the window sum of each beat costs one add.
    // Its register holds the sum and the charger pin level for the scaler.
    logic     sum_valid;
    logic     sum_ready;
    bga_sum_t sum_data;

    // The scaler divides by the window length, scales to millivolts, doubles
    // for the external divider, clamps and forms the percentage. Each stage
    // carries one constant multiplication; every stage advances whenever it
    // is empty or its successor advances, so bubbles close up and the input
    // keeps being accepted while a result waits at the output register, until
    // every stage holds a beat.
    bga_history u_history (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    bga_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
